// ===== rtl/core/blm_pkg.sv =====
// Shared constants and helper functions for the battery level monitor.
package blm_pkg;

	localparam int VOLT_W     = 12;
	localparam int PCT_W      = 7;
	localparam int DIVIDEND_W = VOLT_W + PCT_W;
	localparam int LEVEL_W    = 4;
	localparam int CNT_W      = 3;
	localparam int NORM_W     = 8;
	localparam int CFG_IDX_W  = 2;

	localparam int WINDOW_SAMPLES_DEF = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_POWEROFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WARNING  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FULL     = 2'd2;

	localparam logic [VOLT_W-1:0] POWEROFF_RST = 12'd330;
	localparam logic [VOLT_W-1:0] WARNING_RST  = 12'd340;
	localparam logic [VOLT_W-1:0] FULL_RST     = 12'd420;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_NORMAL  = 3'd1;
	localparam logic [2:0] EV_WARNING = 3'd2;
	localparam logic [2:0] EV_LOW     = 3'd3;
	localparam logic [2:0] EV_CHARGE  = 3'd4;

	localparam logic [1:0] ST_NORMAL   = 2'd0;
	localparam logic [1:0] ST_WARNING  = 2'd1;
	localparam logic [1:0] ST_LOWPOWER = 2'd2;

	localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd9;

	localparam logic [CNT_W-1:0]  LOW_CONFIRM_MAX = 3'd6;
	localparam logic [CNT_W-1:0]  FIRST_WARN_MIN  = 3'd1;
	localparam logic [CNT_W-1:0]  REPEAT_WARN_MIN = 3'd5;
	localparam logic [NORM_W-1:0] NORMAL_MIN      = 8'd2;

	function automatic logic [CNT_W-1:0] sat_inc3(input logic [CNT_W-1:0] v);
		sat_inc3 = (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [NORM_W-1:0] sat_inc8(input logic [NORM_W-1:0] v);
		sat_inc8 = (v == '1) ? v : v + 1'b1;
	endfunction

	// level = (pct - 5) / 10, zero below 5 percent and capped at 9
	function automatic logic [LEVEL_W-1:0] level_of_pct(input logic [PCT_W-1:0] p);
		logic [LEVEL_W-1:0] lvl;
		lvl = '0;
		for (int k = 1; k <= 9; k++) begin
			if (p >= PCT_W'(10 * k + 5))
				lvl = LEVEL_W'(k);
		end
		level_of_pct = lvl;
	endfunction

endpackage

// ===== rtl/core/blm_pct_div.sv =====
// Bit-serial restoring divider producing the percent quotient, one bit per cycle.
module blm_pct_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [blm_pkg::DIVIDEND_W-1:0]     dividend,
	input  logic [blm_pkg::VOLT_W-1:0]         divisor,
	output logic                               done,
	output logic [blm_pkg::PCT_W-1:0]          quotient
);

	localparam int STEP_W = $clog2(blm_pkg::PCT_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(blm_pkg::PCT_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [blm_pkg::VOLT_W-1:0]    rem_q;
	logic [blm_pkg::VOLT_W-1:0]    dvs_q;
	logic [blm_pkg::PCT_W-1:0]     num_q;
	logic [blm_pkg::PCT_W-1:0]     quo_q;
	logic [blm_pkg::VOLT_W:0]      trial;
	logic [blm_pkg::VOLT_W:0]      diff;

	// caller guarantees dividend < divisor << PCT_W, so the upper part is already a remainder
	assign trial = {rem_q, num_q[blm_pkg::PCT_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[blm_pkg::DIVIDEND_W-1:blm_pkg::PCT_W];
			num_q <= dividend[blm_pkg::PCT_W-1:0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[blm_pkg::PCT_W-2:0], 1'b0};
			if (!diff[blm_pkg::VOLT_W]) begin
				rem_q <= diff[blm_pkg::VOLT_W-1:0];
				quo_q <= {quo_q[blm_pkg::PCT_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[blm_pkg::VOLT_W-1:0];
				quo_q <= {quo_q[blm_pkg::PCT_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/battery_level_monitor.sv =====
// Battery level monitor top level: averaging, window status logic and result register.
// Each accepted sample transaction passes the setup states S_PREP and S_CHK. When the
// percent needs the divider, S_DIV waits for the 7 quotient bits from the bit-serial
// divider and takes the quotient; the percent is settled directly in S_CHK when the
// average is at or below power-off, full is not above power-off, or the quotient would
// be 128 or more. S_FIN then commits. A new sample is taken in the cycle after the
// previous result has been written to the output register; the output register lets
// the next sample enter while a result waits, and a result still held by a stalled
// output holds the next one in its commit cycle.
// Configuration is always ready and must only be written while no transaction is in flight.
module battery_level_monitor #(
	parameter int WINDOW_SAMPLES = blm_pkg::WINDOW_SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [blm_pkg::VOLT_W-1:0]        battery_sample,
	input  logic                              hw_low_flag,
	input  logic                              charger_present,
	input  logic                              warn_repeat_busy,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        power_event,
	output logic                              level_changed,
	output logic [1:0]                        battery_status,
	output logic [blm_pkg::LEVEL_W-1:0]       gauge_level,
	output logic [blm_pkg::VOLT_W-1:0]        averaged_voltage,
	output logic                              window_done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [blm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [blm_pkg::VOLT_W-1:0]        cfg_data
);

	localparam logic [blm_pkg::CNT_W-1:0] WIN_LEN  = blm_pkg::CNT_W'(WINDOW_SAMPLES);
	localparam logic [blm_pkg::CNT_W-1:0] WIN_HALF = blm_pkg::CNT_W'(WINDOW_SAMPLES / 2);

	typedef enum logic [2:0] {S_IDLE, S_PREP, S_CHK, S_DIV, S_FIN} state_t;

	state_t                            state_q;

	logic [blm_pkg::VOLT_W-1:0]        poweroff_q, warning_q, full_q;
	logic [blm_pkg::VOLT_W-1:0]        avg_q;
	logic                              hw_low_q, charger_q, busy_q;

	logic [blm_pkg::CNT_W-1:0]         sample_cnt_q, off_hits_q, warn_hits_q;
	logic [blm_pkg::CNT_W-1:0]         low_conf_q, warn_rep_q;
	logic [blm_pkg::NORM_W-1:0]        norm_conf_q;
	logic                              first_warn_q;
	logic [1:0]                        status_q;
	logic [blm_pkg::LEVEL_W-1:0]       prev_level_q;
	logic                              prev_charger_q;

	logic                              zero_pct_q, full_sat_q;
	logic [blm_pkg::VOLT_W-1:0]        span_q;
	logic [blm_pkg::DIVIDEND_W-1:0]    dividend_q;
	logic [blm_pkg::PCT_W-1:0]         pct_q;

	logic                              out_valid_q;
	logic [2:0]                        event_q;
	logic                              changed_q, done_q;
	logic [1:0]                        status_out_q;
	logic [blm_pkg::LEVEL_W-1:0]       level_out_q;
	logic [blm_pkg::VOLT_W-1:0]        avg_out_q;

	logic                              in_acc, out_acc, commit;
	logic [blm_pkg::VOLT_W-1:0]        avg_new;
	logic [blm_pkg::VOLT_W-1:0]        diff_po;
	logic [blm_pkg::DIVIDEND_W-1:0]    diff_ext, dividend_new;
	logic                              le_po, le_warn;
	logic                              div_start, div_done;
	logic [blm_pkg::PCT_W-1:0]         div_quo;
	logic                              div_over;

	// window close results
	logic [blm_pkg::LEVEL_W-1:0]       level_now;
	logic [2:0]                        ev_n;
	logic                              changed_n, done_n;
	logic [1:0]                        status_n;
	logic [blm_pkg::CNT_W-1:0]         low_conf_n, warn_rep_n;
	logic [blm_pkg::NORM_W-1:0]        norm_conf_n;
	logic                              first_warn_n;
	logic [blm_pkg::LEVEL_W-1:0]       prev_level_n;
	logic                              prev_charger_n;
	logic                              win_end;

	function automatic logic [blm_pkg::VOLT_W-1:0] avg_sum_half(
		input logic [blm_pkg::VOLT_W-1:0] a,
		input logic [blm_pkg::VOLT_W-1:0] b
	);
		logic [blm_pkg::VOLT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		avg_sum_half = s[blm_pkg::VOLT_W:1];
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign commit    = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	assign avg_new = (avg_q == '0) ? battery_sample
		: avg_sum_half(battery_sample, avg_q);

	assign le_po   = (avg_q <= poweroff_q);
	assign le_warn = (avg_q <= warning_q);
	assign diff_po = avg_q - poweroff_q;
	assign diff_ext = {{blm_pkg::PCT_W{1'b0}}, diff_po};
	// times 100 = 64 + 32 + 4
	assign dividend_new = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);

	assign div_over  = (dividend_q >= {span_q, {blm_pkg::PCT_W{1'b0}}});
	assign div_start = (state_q == S_CHK) && !zero_pct_q && !full_sat_q && !div_over;

	blm_pct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend_q),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign level_now = blm_pkg::level_of_pct(pct_q);
	assign win_end   = (sample_cnt_q >= WIN_LEN);

	always_comb begin
		ev_n           = blm_pkg::EV_NONE;
		changed_n      = 1'b0;
		done_n         = 1'b0;
		status_n       = status_q;
		low_conf_n     = low_conf_q;
		warn_rep_n     = warn_rep_q;
		norm_conf_n    = norm_conf_q;
		first_warn_n   = first_warn_q;
		prev_level_n   = prev_level_q;
		prev_charger_n = prev_charger_q;
		if (win_end) begin
			if (!charger_q) begin
				if (off_hits_q > WIN_HALF) begin
					low_conf_n  = blm_pkg::sat_inc3(low_conf_q);
					warn_rep_n  = '0;
					norm_conf_n = '0;
					status_n    = blm_pkg::ST_LOWPOWER;
					if (low_conf_n > blm_pkg::LOW_CONFIRM_MAX) begin
						low_conf_n = '0;
						ev_n       = blm_pkg::EV_LOW;
						done_n     = 1'b1;
					end
				end else if (warn_hits_q > WIN_HALF) begin
					warn_rep_n  = blm_pkg::sat_inc3(warn_rep_q);
					low_conf_n  = '0;
					norm_conf_n = '0;
					status_n    = blm_pkg::ST_WARNING;
					if ((first_warn_q && warn_rep_n > blm_pkg::FIRST_WARN_MIN) ||
					    (!first_warn_q && warn_rep_n >= blm_pkg::REPEAT_WARN_MIN)) begin
						first_warn_n = 1'b0;
						warn_rep_n   = '0;
						if (!busy_q)
							ev_n = blm_pkg::EV_WARNING;
					end
				end else begin
					norm_conf_n = blm_pkg::sat_inc8(norm_conf_q);
					warn_rep_n  = '0;
					low_conf_n  = '0;
					if (norm_conf_n > blm_pkg::NORMAL_MIN && status_q != blm_pkg::ST_NORMAL) begin
						status_n = blm_pkg::ST_NORMAL;
						ev_n     = blm_pkg::EV_NORMAL;
					end
				end
			end else begin
				ev_n = blm_pkg::EV_CHARGE;
			end
			if (status_n != blm_pkg::ST_LOWPOWER) begin
				done_n = 1'b1;
				if (level_now != prev_level_q || prev_charger_q != charger_q)
					changed_n = 1'b1;
				prev_charger_n = charger_q;
				prev_level_n   = level_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			poweroff_q     <= blm_pkg::POWEROFF_RST;
			warning_q      <= blm_pkg::WARNING_RST;
			full_q         <= blm_pkg::FULL_RST;
			avg_q          <= '0;
			sample_cnt_q   <= '0;
			off_hits_q     <= '0;
			warn_hits_q    <= '0;
			low_conf_q     <= '0;
			warn_rep_q     <= '0;
			norm_conf_q    <= '0;
			first_warn_q   <= 1'b1;
			status_q       <= blm_pkg::ST_NORMAL;
			prev_level_q   <= blm_pkg::LEVEL_MAX;
			prev_charger_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					blm_pkg::CFG_IDX_POWEROFF: poweroff_q <= cfg_data;
					blm_pkg::CFG_IDX_WARNING:  warning_q  <= cfg_data;
					blm_pkg::CFG_IDX_FULL:     full_q     <= cfg_data;
					default: ;
				endcase
			end

			// a commit may refill the output register in the cycle it is taken
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_acc)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						avg_q   <= avg_new;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					sample_cnt_q <= blm_pkg::sat_inc3(sample_cnt_q);
					if (hw_low_q || le_po)
						off_hits_q <= blm_pkg::sat_inc3(off_hits_q);
					if (le_warn)
						warn_hits_q <= blm_pkg::sat_inc3(warn_hits_q);
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= div_start ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (commit) begin
						low_conf_q     <= low_conf_n;
						warn_rep_q     <= warn_rep_n;
						norm_conf_q    <= norm_conf_n;
						first_warn_q   <= first_warn_n;
						status_q       <= status_n;
						prev_level_q   <= prev_level_n;
						prev_charger_q <= prev_charger_n;
						if (win_end) begin
							sample_cnt_q <= '0;
							off_hits_q   <= '0;
							warn_hits_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// transaction payload and result registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hw_low_q  <= hw_low_flag;
			charger_q <= charger_present;
			busy_q    <= warn_repeat_busy;
		end
		if (state_q == S_PREP) begin
			zero_pct_q <= le_po;
			full_sat_q <= (full_q <= poweroff_q);
			span_q     <= full_q - poweroff_q;
			dividend_q <= dividend_new;
		end
		if (state_q == S_CHK) begin
			if (zero_pct_q)
				pct_q <= '0;
			else if (full_sat_q || div_over)
				pct_q <= blm_pkg::PCT_FULL;
		end
		if (state_q == S_DIV && div_done)
			pct_q <= (div_quo > blm_pkg::PCT_FULL) ? blm_pkg::PCT_FULL : div_quo;
		if (commit) begin
			event_q      <= ev_n;
			changed_q    <= changed_n;
			done_q       <= done_n;
			status_out_q <= status_n;
			level_out_q  <= level_now;
			avg_out_q    <= avg_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign power_event      = event_q;
	assign level_changed    = changed_q;
	assign battery_status   = status_out_q;
	assign gauge_level      = level_out_q;
	assign averaged_voltage = avg_out_q;
	assign window_done      = done_q;

endmodule
